### rtl/core/spr_pkg.sv
// Shared types, register offsets and helpers for the serial port register FIFO block.
package spr_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  localparam logic [CNT_W-1:0] CAP_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] CAP_HALF = CNT_W'(FIFO_DEPTH / 2);

  localparam logic [5:0] LONG_WORD = 6'd16;

  localparam logic [6:0] OFS_TCR1 = 7'h00;
  localparam logic [6:0] OFS_TCR2 = 7'h04;
  localparam logic [6:0] OFS_TX   = 7'h10;
  localparam logic [6:0] OFS_RX   = 7'h18;
  localparam logic [6:0] OFS_RCR1 = 7'h20;
  localparam logic [6:0] OFS_RCR2 = 7'h24;
  localparam logic [6:0] OFS_STAT = 7'h30;

  typedef enum logic [1:0] {
    ACT_READ    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_RX_WORD = 2'd2,
    ACT_TX_TAKE = 2'd3
  } action_e;

  typedef struct packed {
    logic       right_first;
    logic       secondary;
    logic       stereo;
    logic [4:0] len;
    logic       lsb_first;
    logic [1:0] fmt;
    logic       enable;
  } ctl_t;

  typedef struct packed {
    logic tovf;
    logic tuvf;
    logic rovf;
    logic ruvf;
  } flags_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic        long_word;
    logic [31:0] wdata;
  } fifo_cmd_t;

  typedef struct packed {
    logic        empty;
    logic        full;
    logic [31:0] rdata;
  } fifo_sts_t;

  typedef struct packed {
    action_e     action;
    logic [6:0]  ofs;
    logic [31:0] data;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] line_word;
    logic        line_word_valid;
  } result_t;

  function automatic logic is_long(logic [4:0] len);
    return ({1'b0, len} + 6'd1) > LONG_WORD;
  endfunction

  function automatic logic [31:0] rd_cr1(ctl_t c);
    return {27'd0, c.lsb_first, c.fmt, 1'b0, c.enable};
  endfunction

  function automatic logic [31:0] rd_cr2(ctl_t c);
    return {21'd0, c.right_first, c.secondary, c.stereo, 3'd0, c.len};
  endfunction

endpackage

### rtl/core/spr_fifo.sv
// Word FIFO in flip-flops with a capacity that halves for long words.
module spr_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spr_pkg::fifo_cmd_t  cmd_i,
  output spr_pkg::fifo_sts_t  sts_o
);

  logic [31:0]               mem_q [spr_pkg::FIFO_DEPTH];
  logic [spr_pkg::IDX_W-1:0] head_q, head_d;
  logic [spr_pkg::CNT_W-1:0] count_q, count_d;
  logic [spr_pkg::CNT_W-1:0] cap;
  logic [spr_pkg::IDX_W:0]   wsum;
  logic [spr_pkg::IDX_W-1:0] waddr;
  logic                      full, empty, do_push, do_pop;

  always_comb begin
    cap     = cmd_i.long_word ? spr_pkg::CAP_HALF : spr_pkg::CAP_FULL;
    full    = count_q >= cap;
    empty   = count_q == '0;
    do_push = cmd_i.push && !full;
    do_pop  = cmd_i.pop && !empty;
    wsum    = (spr_pkg::IDX_W+1)'(head_q) + (spr_pkg::IDX_W+1)'(count_q);
    if (wsum >= (spr_pkg::IDX_W+1)'(spr_pkg::FIFO_DEPTH)) begin
      wsum = wsum - (spr_pkg::IDX_W+1)'(spr_pkg::FIFO_DEPTH);
    end
    waddr   = wsum[spr_pkg::IDX_W-1:0];
    head_d  = head_q;
    count_d = count_q;
    if (do_push) begin
      count_d = count_q + 1'b1;
    end
    if (do_pop) begin
      count_d = count_q - 1'b1;
      if (head_q == spr_pkg::IDX_W'(spr_pkg::FIFO_DEPTH - 1)) begin
        head_d = '0;
      end else begin
        head_d = head_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[waddr] <= cmd_i.wdata;
    end
  end

  assign sts_o.empty = empty;
  assign sts_o.full  = full;
  assign sts_o.rdata = mem_q[head_q];

endmodule

### rtl/core/spr_core.sv
// Register decode, control registers, sticky flags and FIFO commands.
module spr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  spr_pkg::item_t      item_i,
  input  spr_pkg::fifo_sts_t  tx_sts_i,
  input  spr_pkg::fifo_sts_t  rx_sts_i,
  output spr_pkg::fifo_cmd_t  tx_cmd_o,
  output spr_pkg::fifo_cmd_t  rx_cmd_o,
  output spr_pkg::result_t    res_o
);

  spr_pkg::ctl_t   tx_ctl_q, tx_ctl_d;
  spr_pkg::ctl_t   rx_ctl_q, rx_ctl_d;
  spr_pkg::flags_t flags_q, flags_d;

  always_comb begin
    tx_ctl_d  = tx_ctl_q;
    rx_ctl_d  = rx_ctl_q;
    flags_d   = flags_q;
    res_o     = '0;
    tx_cmd_o  = '0;
    rx_cmd_o  = '0;
    tx_cmd_o.long_word = spr_pkg::is_long(tx_ctl_q.len);
    rx_cmd_o.long_word = spr_pkg::is_long(rx_ctl_q.len);
    tx_cmd_o.wdata     = item_i.data;
    rx_cmd_o.wdata     = item_i.data;
    if (fire_i) begin
      case (item_i.action)
        spr_pkg::ACT_READ: begin
          case (item_i.ofs)
            spr_pkg::OFS_TCR1: res_o.read_data = spr_pkg::rd_cr1(tx_ctl_q);
            spr_pkg::OFS_TCR2: res_o.read_data = spr_pkg::rd_cr2(tx_ctl_q);
            spr_pkg::OFS_RCR1: res_o.read_data = spr_pkg::rd_cr1(rx_ctl_q);
            spr_pkg::OFS_RCR2: res_o.read_data = spr_pkg::rd_cr2(rx_ctl_q);
            spr_pkg::OFS_RX: begin
              rx_cmd_o.pop = 1'b1;
              if (rx_sts_i.empty) begin
                flags_d.ruvf = 1'b1;
              end else begin
                res_o.read_data = rx_sts_i.rdata;
              end
            end
            spr_pkg::OFS_STAT: begin
              res_o.read_data = {25'd0, 1'b0, flags_q.tovf, flags_q.tuvf, tx_sts_i.full,
                                 flags_q.rovf, flags_q.ruvf, !rx_sts_i.empty};
            end
            default: res_o.read_data = '0;
          endcase
        end
        spr_pkg::ACT_WRITE: begin
          case (item_i.ofs)
            spr_pkg::OFS_TCR1: begin
              tx_ctl_d.enable    = item_i.data[0];
              tx_ctl_d.fmt       = item_i.data[3:2];
              tx_ctl_d.lsb_first = item_i.data[4];
              if (!item_i.data[0]) begin
                flags_d.tovf = 1'b0;
                flags_d.tuvf = 1'b0;
              end
            end
            spr_pkg::OFS_TCR2: begin
              tx_ctl_d.len         = item_i.data[4:0];
              tx_ctl_d.stereo      = item_i.data[8];
              tx_ctl_d.secondary   = item_i.data[9];
              tx_ctl_d.right_first = item_i.data[10];
            end
            spr_pkg::OFS_RCR1: begin
              rx_ctl_d.enable    = item_i.data[0];
              rx_ctl_d.fmt       = item_i.data[3:2];
              rx_ctl_d.lsb_first = item_i.data[4];
              if (!item_i.data[0]) begin
                flags_d.rovf = 1'b0;
                flags_d.ruvf = 1'b0;
              end
            end
            spr_pkg::OFS_RCR2: begin
              rx_ctl_d.len         = item_i.data[4:0];
              rx_ctl_d.stereo      = item_i.data[8];
              rx_ctl_d.secondary   = item_i.data[9];
              rx_ctl_d.right_first = item_i.data[10];
            end
            spr_pkg::OFS_TX: begin
              tx_cmd_o.push = 1'b1;
              if (tx_sts_i.full) begin
                flags_d.tovf = 1'b1;
              end
            end
            spr_pkg::OFS_STAT: begin
              flags_d.ruvf = flags_q.ruvf & ~item_i.data[1];
              flags_d.rovf = flags_q.rovf & ~item_i.data[2];
              flags_d.tuvf = flags_q.tuvf & ~item_i.data[4];
              flags_d.tovf = flags_q.tovf & ~item_i.data[5];
            end
            default: ;
          endcase
        end
        spr_pkg::ACT_RX_WORD: begin
          rx_cmd_o.push = 1'b1;
          if (rx_sts_i.full) begin
            flags_d.rovf = 1'b1;
          end
        end
        spr_pkg::ACT_TX_TAKE: begin
          tx_cmd_o.pop = 1'b1;
          if (tx_sts_i.empty) begin
            flags_d.tuvf = 1'b1;
          end else begin
            res_o.line_word       = tx_sts_i.rdata;
            res_o.line_word_valid = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_ctl_q <= '0;
      rx_ctl_q <= '0;
      flags_q  <= '0;
    end else begin
      tx_ctl_q <= tx_ctl_d;
      rx_ctl_q <= rx_ctl_d;
      flags_q  <= flags_d;
    end
  end

endmodule

### rtl/core/serial_port_register_fifo.sv
// Top level of the serial port register FIFO block: input and result registers.
// Each accepted word waits in the input register; once the result register is free, its result is registered there.
// Throughput: one word per cycle unless the result output stalls, with decode and FIFO update done as the word fires.
// Reset (async, active low) clears control registers, FIFO counts and sticky flags;
// FIFO storage is not cleared.
module serial_port_register_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // reg_offset[6:0], data_in[38:7], zero pad[39]
  input  logic [1:0]  s_axis_tuser_i,   // action[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // read_data[31:0], line_word[63:32]
  output logic [0:0]  m_axis_tuser_o    // line_word_valid[0]
);

  logic               in_valid_q, in_valid_d;
  spr_pkg::item_t     in_q;
  logic               out_valid_q, out_valid_d;
  spr_pkg::result_t   out_q;
  spr_pkg::result_t   res;
  spr_pkg::fifo_cmd_t tx_cmd, rx_cmd;
  spr_pkg::fifo_sts_t tx_sts, rx_sts;
  logic               fire, accept;

  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.action <= spr_pkg::action_e'(s_axis_tuser_i);
      in_q.ofs    <= s_axis_tdata_i[6:0];
      in_q.data   <= s_axis_tdata_i[38:7];
    end
    if (fire) begin
      out_q <= res;
    end
  end

  spr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .tx_sts_i (tx_sts),
    .rx_sts_i (rx_sts),
    .tx_cmd_o (tx_cmd),
    .rx_cmd_o (rx_cmd),
    .res_o    (res)
  );

  spr_fifo u_tx_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (tx_cmd),
    .sts_o  (tx_sts)
  );

  spr_fifo u_rx_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (rx_cmd),
    .sts_o  (rx_sts)
  );

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = {out_q.line_word, out_q.read_data};
  assign m_axis_tuser_o[0] = out_q.line_word_valid;

  a_no_fire_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !fire)
    else $error("word processed while result stalled");

  a_take_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_cmd.pop && !tx_sts.empty |=> out_q.line_word_valid && out_valid_q)
    else $error("transmit take from non-empty FIFO lost its word");

  a_no_stray_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.line_word_valid |-> out_q.line_word == '0)
    else $error("line word nonzero without valid flag");

endmodule
